@@ rtl/core/nine_to_eight_bit_packer_macros.svh @@
// Assertion macros for the nine-to-eight bit packer.
// Used by nine_to_eight_bit_packer.sv; expects signals clock and reset in scope.
`ifndef NINE_TO_EIGHT_BIT_PACKER_MACROS_SVH
`define NINE_TO_EIGHT_BIT_PACKER_MACROS_SVH

// check prop at every rising clock edge outside reset
`define NEBP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check prop at every rising clock edge, reset included
`define NEBP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/nebp_pkg.sv @@
// Package for the nine-to-eight bit packer: constants and the result type.
// No dependencies.
`default_nettype none

package nebp_pkg;

   localparam int unsigned WordWidth  = 16;
   localparam int unsigned InBits     = 9;
   localparam int unsigned OutBits    = 8;
   localparam int unsigned PendWidth  = InBits - 2;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned AccWidth   = PendWidth + InBits;
   localparam int unsigned ResDepth   = 2;
   localparam int unsigned ResCntW    = $clog2(ResDepth + 1);

   typedef struct packed {
      logic [OutBits-1:0] byte_out;
      logic               byte_valid;
      logic               range_error;
      logic               run_last;
      logic               stream_done;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/nine_to_eight_bit_packer.sv @@
// Nine-to-eight bit packer: input register, packing logic, result buffer, output register.
// Depends on nebp_pkg and nine_to_eight_bit_packer_macros.svh.
//
// Usage:
//   req_ channel takes one 16-bit word per transaction (req_word_in, req_end_of_stream).
//   Values below 512 are packed MSB-first; complete bytes leave on the rsp_ channel,
//   one result per transaction. The word marked end of stream flushes any leftover
//   bits as one byte, zero-padded at the bottom.
//   A word of 512 or more gives one error result and the stream is dropped up to and
//   including its end marker, which then gives no result.
// Path: an accepted word goes through the input register, the result buffer and the output
//   register to rsp_. Throughput: one result per cycle while rsp_ready is high; a word
//   gives at most two results, so the single result port and two-entry buffer set the word rate.
// Reset: synchronous, active high; clears pending bits, the abort flag, the buffer count and
//   the input and output valid flags; req_ready is high in reset from its first clock edge on.
// Stall: while rsp_ready is low the output register holds its result, the buffer and
//   input register fill, and req_ready falls; nothing is lost.
`default_nettype none
`include "nine_to_eight_bit_packer_macros.svh"

module nine_to_eight_bit_packer
   import nebp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [WordWidth-1:0] req_word_in,
   input  wire logic                 req_end_of_stream,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [OutBits-1:0]        rsp_byte_out,
   output logic                      rsp_byte_valid,
   output logic                      rsp_range_error,
   output logic                      rsp_run_last,
   output logic                      rsp_stream_done
);

   logic                  in_valid_ff, in_valid_in;
   logic [WordWidth-1:0]  in_word_ff;
   logic                  in_eos_ff;

   logic [PendWidth-1:0]  pend_bits_ff, pend_bits_in;
   logic [CountWidth-1:0] pend_cnt_ff, pend_cnt_in;
   logic                  aborted_ff, aborted_in;

   result_type            buf_ff [ResDepth];
   logic [ResCntW-1:0]    cnt_ff, cnt_in;

   result_type            rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  out_load, b_free, a_fire, req_fire;

   result_type            new_res [ResDepth];
   logic [ResCntW-1:0]    new_cnt;

   logic [AccWidth-1:0]   acc;
   logic [3:0]            shift;
   logic [OutBits-1:0]    first_byte;
   logic [CountWidth-1:0] rem_len;
   logic [PendWidth-1:0]  rem_mask, rem_bits;
   logic [AccWidth-1:0]   flush_wide;
   logic                  full_pend;

   // handshake
   assign out_load  = (!rsp_valid_ff || rsp_ready) && (cnt_ff != '0);
   assign b_free    = (cnt_ff == '0) || ((cnt_ff == ResCntW'(1)) && out_load);
   assign a_fire    = in_valid_ff && b_free;
   assign req_ready = !in_valid_ff || a_fire;
   assign req_fire  = req_valid && req_ready;

   // packing
   always_comb begin
      acc        = {pend_bits_ff, in_word_ff[InBits-1:0]};
      shift      = {1'b0, pend_cnt_ff} + 4'd1;
      first_byte = OutBits'(acc >> shift);
      full_pend  = (pend_cnt_ff == CountWidth'(PendWidth));
      rem_len    = full_pend ? '0 : pend_cnt_ff + CountWidth'(1);
      rem_mask   = PendWidth'((8'd1 << rem_len) - 8'd1);
      rem_bits   = acc[PendWidth-1:0] & rem_mask;
      flush_wide = AccWidth'(rem_bits) << (4'd8 - {1'b0, rem_len});

      for (int i = 0; i < ResDepth; i++) begin
         new_res[i] = '0;
      end
      new_cnt      = '0;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      aborted_in   = aborted_ff;

      if (a_fire) begin
         if (aborted_ff) begin
            if (in_eos_ff) begin
               pend_bits_in = '0;
               pend_cnt_in  = '0;
               aborted_in   = 1'b0;
            end
         end else if (in_word_ff[WordWidth-1:InBits] != '0) begin
            new_res[0].range_error = 1'b1;
            new_res[0].run_last    = 1'b1;
            new_res[0].stream_done = in_eos_ff;
            new_cnt      = ResCntW'(1);
            pend_bits_in = '0;
            pend_cnt_in  = '0;
            aborted_in   = !in_eos_ff;
         end else begin
            new_res[0].byte_out   = first_byte;
            new_res[0].byte_valid = 1'b1;
            if (full_pend || in_eos_ff) begin
               new_res[1].byte_out    = full_pend ? acc[OutBits-1:0] : flush_wide[OutBits-1:0];
               new_res[1].byte_valid  = 1'b1;
               new_res[1].run_last    = 1'b1;
               new_res[1].stream_done = in_eos_ff;
               new_cnt = ResCntW'(2);
            end else begin
               new_res[0].run_last = 1'b1;
               new_cnt = ResCntW'(1);
            end
            if (in_eos_ff) begin
               pend_bits_in = '0;
               pend_cnt_in  = '0;
            end else begin
               pend_bits_in = rem_bits;
               pend_cnt_in  = rem_len;
            end
         end
      end
   end

   always_comb begin
      in_valid_in = req_fire || (in_valid_ff && !a_fire);
      if (a_fire) begin
         cnt_in = new_cnt;
      end else if (out_load) begin
         cnt_in = cnt_ff - ResCntW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         aborted_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         aborted_ff   <= aborted_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_word_in;
         in_eos_ff  <= req_end_of_stream;
      end
      if (a_fire) begin
         buf_ff[0] <= new_res[0];
         buf_ff[1] <= new_res[1];
      end else if (out_load) begin
         buf_ff[0] <= buf_ff[1];
      end
      if (out_load) begin
         rsp_ff <= buf_ff[0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_out    = rsp_ff.byte_out;
   assign rsp_byte_valid  = rsp_ff.byte_valid;
   assign rsp_range_error = rsp_ff.range_error;
   assign rsp_run_last    = rsp_ff.run_last;
   assign rsp_stream_done = rsp_ff.stream_done;

   `NEBP_ASSERT(a_buf_bound, cnt_ff <= ResCntW'(ResDepth), "result buffer overfilled")
   `NEBP_ASSERT(a_eos_clears, (a_fire && in_eos_ff) |=> (pend_cnt_ff == '0 && !aborted_ff), "end of stream left state behind")
   `NEBP_ASSERT(a_abort_empty, aborted_ff |-> (pend_cnt_ff == '0), "pending bits kept while aborted")
   `NEBP_ASSERT(a_err_shape, (rsp_valid_ff && rsp_ff.range_error) |-> (rsp_ff.run_last && !rsp_ff.byte_valid), "malformed error result")

endmodule

`default_nettype wire

@@ dv/nine_to_eight_bit_packer_test.sv @@
// Testbench for nine_to_eight_bit_packer: directed and random word streams on req_,
// packed bytes checked on rsp_ against a bit-accurate packing predictor.
// Depends on nebp_pkg and the nine_to_eight_bit_packer RTL.
module nine_to_eight_bit_packer_test
   import nebp_pkg::*;
;

   localparam int unsigned WordLimit     = 1 << InBits;
   localparam int unsigned WatchdogLimit = 500;
   localparam int unsigned DrainCycles   = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WordWidth-1:0] req_word_in = '0;
   logic                 req_end_of_stream = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OutBits-1:0]   rsp_byte_out;
   logic                 rsp_byte_valid;
   logic                 rsp_range_error;
   logic                 rsp_run_last;
   logic                 rsp_stream_done;

   logic [PendWidth-1:0]  held_bits = '0;
   logic [CountWidth-1:0] held_count = '0;
   logic                  dropping = 1'b0;
   result_type            expected_bytes[$];
   int unsigned           words_packed = 0;
   int unsigned           mismatch_count = 0;
   bit                    idle_en = 1'b1;

   nine_to_eight_bit_packer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_word_in       (req_word_in),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_range_error   (rsp_range_error),
      .rsp_run_last      (rsp_run_last),
      .rsp_stream_done   (rsp_stream_done)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void pack_word(input logic [WordWidth-1:0] word, input logic eos);
      logic [31:0] acc;
      int unsigned len;
      int unsigned full;
      logic        flush;
      logic        last;
      result_type  r;
      words_packed++;
      if (dropping) begin
         if (eos) begin
            dropping   = 1'b0;
            held_bits  = '0;
            held_count = '0;
         end
         return;
      end
      if (word >= WordLimit) begin
         r = '{byte_out: 8'h00, byte_valid: 1'b0, range_error: 1'b1, run_last: 1'b1,
               stream_done: eos};
         expected_bytes.push_back(r);
         held_bits  = '0;
         held_count = '0;
         dropping   = !eos;
         return;
      end
      len   = held_count + InBits;
      acc   = {16'h0000, held_bits, word[InBits-1:0]};
      full  = len / OutBits;
      flush = eos && (len % OutBits != 0);
      for (int unsigned i = 0; i < full; i++) begin
         len -= OutBits;
         last = (i == full - 1) && !flush;
         r = '{byte_out: 8'(acc >> len), byte_valid: 1'b1, range_error: 1'b0,
               run_last: last, stream_done: last && eos};
         expected_bytes.push_back(r);
         acc &= (32'd1 << len) - 32'd1;
      end
      if (flush) begin
         r = '{byte_out: 8'(acc << (OutBits - len)), byte_valid: 1'b1, range_error: 1'b0,
               run_last: 1'b1, stream_done: 1'b1};
         expected_bytes.push_back(r);
         len = 0;
         acc = '0;
      end
      if (eos) begin
         held_bits  = '0;
         held_count = '0;
      end else begin
         held_bits  = acc[PendWidth-1:0];
         held_count = len[CountWidth-1:0];
      end
   endfunction

   // call at a falling edge; returns at the falling edge after the transaction
   task automatic send_word(input logic [WordWidth-1:0] word, input logic eos);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_word_in       <= word;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pack_word(word, eos);
      @(negedge clock);
   endtask

   task automatic send_stream(input int unsigned len, input int error_at);
      logic [WordWidth-1:0] word;
      for (int unsigned i = 0; i < len; i++) begin
         if (i == error_at) word = WordWidth'($urandom_range(WordLimit, 16'hFFFF));
         else word = WordWidth'($urandom_range(0, WordLimit - 1));
         send_word(word, i == len - 1);
      end
   endtask

   task automatic test_bit_patterns();
      send_word(16'h0000, 1'b0);
      send_word(16'h01FF, 1'b0);
      send_word(16'h0155, 1'b0);
      send_word(16'h00AA, 1'b0);
      send_word(16'h01FF, 1'b1);
   endtask

   // eight words fill exactly nine bytes: no flush byte
   task automatic test_byte_boundary();
      for (int unsigned i = 0; i < 8; i++) send_word(WordWidth'(1 << i), i == 7);
   endtask

   task automatic test_out_of_range();
      send_word(16'h00F3, 1'b0);
      send_word(16'h0200, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0003, 1'b0);
      send_word(16'h0007, 1'b1);
      send_word(16'h0005, 1'b1);
      send_word(16'h8000, 1'b1);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h0000, 1'b1);
   endtask

   task automatic test_random_streams();
      int unsigned goal;
      int unsigned len;
      int unsigned pick;
      goal = words_packed + 330;
      while (words_packed < goal) begin
         pick = $urandom_range(0, 9);
         len  = $urandom_range(1, 20);
         if (pick < 8) begin
            send_stream(len, -1);
         end else if (pick == 8) begin
            send_stream(len, $urandom_range(0, len - 1));
         end else begin
            repeat (len) send_word(WordWidth'($urandom()), 1'($urandom_range(0, 3) == 0));
         end
      end
   endtask

   task automatic test_full_rate_streams();
      int unsigned goal;
      idle_en = 1'b0;
      goal = words_packed + 60;
      while (words_packed < goal) send_stream($urandom_range(1, 12), -1);
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_bit_patterns();
      test_byte_boundary();
      test_out_of_range();
      test_random_streams();
      test_full_rate_streams();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected transaction on rsp_: byte_out %0h", rsp_byte_out);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_byte_out !== want.byte_out) begin
               $error("byte_out: expected %0h, actual %0h", want.byte_out, rsp_byte_out);
               mismatch_count++;
            end
            if (rsp_byte_valid !== want.byte_valid) begin
               $error("byte_valid: expected %0b, actual %0b", want.byte_valid, rsp_byte_valid);
               mismatch_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error: expected %0b, actual %0b", want.range_error,
                      rsp_range_error);
               mismatch_count++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, actual %0b", want.run_last, rsp_run_last);
               mismatch_count++;
            end
            if (rsp_stream_done !== want.stream_done) begin
               $error("stream_done: expected %0b, actual %0b", want.stream_done,
                      rsp_stream_done);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      int unsigned quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
